// ===== rtl/mavg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average package
// Shared types and command and status bundles for the moving average block.
// ----------------------------------------------------------------------------
package mavg_pkg;

	localparam int SAMPLE_W = 16;
	localparam int FILL_W   = 4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [FILL_W-1:0]          fill_t;

	typedef struct packed {
		logic capture;
		logic read;
		logic update;
		logic div_load;
		logic div_step;
		logic out_load;
	} mavg_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} mavg_status_t;

endpackage

// ===== rtl/mavg_smp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid and ready handshake carrying one signed sensor sample per word.
// ----------------------------------------------------------------------------
interface mavg_smp_if;
	logic              valid;
	logic              ready;
	mavg_pkg::sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/mavg_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid and ready handshake carrying the mean and the fill count per word.
// ----------------------------------------------------------------------------
interface mavg_res_if;
	logic              valid;
	logic              ready;
	mavg_pkg::sample_t mean;
	mavg_pkg::fill_t   fill_count;

	modport source (output valid, output mean, output fill_count, input ready);
	modport sink (input valid, input mean, input fill_count, output ready);
endinterface

// ===== rtl/mavg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mavg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/mavg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average controller
// Sequences ring read, sum update, serial division and result hand-off.
// ----------------------------------------------------------------------------
module mavg_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  mavg_pkg::mavg_status_t status,
	output mavg_pkg::mavg_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_LOAD = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d    = S_LOAD;
			end
			S_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("More than one datapath command at once.");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && status.div_done) |=> (state_q == S_DONE))
		else $error("Division finished without moving to the hand-off state.");

endmodule

// ===== rtl/mavg_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average datapath
// Sample ring, running sum, serial restoring divider and output register.
// ----------------------------------------------------------------------------
module mavg_dpath #(
	parameter int WINDOW = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mavg_pkg::mavg_cmd_t    cmd,
	output mavg_pkg::mavg_status_t status,
	input  mavg_pkg::sample_t      sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output mavg_pkg::sample_t      mean,
	output mavg_pkg::fill_t        fill_count
);

	localparam int PTR_W  = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = mavg_pkg::SAMPLE_W + $clog2(WINDOW);
	localparam int STEP_W = $clog2(SUM_W);

	mavg_pkg::sample_t         sample_q;
	logic [PTR_W-1:0]          ptr_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]          quo_q;
	logic [CNT_W-1:0]          rem_q;
	logic                      neg_q;
	logic [STEP_W-1:0]         step_q;
	logic                      out_valid_q;
	mavg_pkg::sample_t         mean_q;
	mavg_pkg::fill_t           fill_q;

	logic [mavg_pkg::SAMPLE_W-1:0] ram_rdata;
	mavg_pkg::sample_t             old_val;
	logic                          full;
	logic [CNT_W:0]                trial;
	logic [CNT_W:0]                div_ext;
	logic                          fits;
	logic [SUM_W-1:0]              sum_mag;

	mavg_ram #(
		.WIDTH(mavg_pkg::SAMPLE_W),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (cmd.update),
		.waddr(ptr_q),
		.wdata(sample_q),
		.re   (cmd.read),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	// Until the ring has filled, the slot under the pointer has never been written.
	assign full    = (cnt_q == CNT_W'(WINDOW));
	assign old_val = full ? mavg_pkg::sample_t'(ram_rdata) : '0;

	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign trial   = {rem_q, quo_q[SUM_W-1]};
	assign div_ext = {1'b0, cnt_q};
	assign fits    = (trial >= div_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
		end else if (cmd.update) begin
			sum_q <= sum_q - SUM_W'(old_val) + SUM_W'(sample_q);
			ptr_q <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
			if (!full) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
		end
		if (cmd.div_load) begin
			quo_q  <= sum_mag;
			rem_q  <= '0;
			neg_q  <= sum_q[SUM_W-1];
			step_q <= STEP_W'(SUM_W - 1);
		end else if (cmd.div_step) begin
			quo_q  <= {quo_q[SUM_W-2:0], fits};
			rem_q  <= fits ? CNT_W'(trial - div_ext) : CNT_W'(trial);
			step_q <= step_q - 1'b1;
		end
		if (cmd.out_load) begin
			mean_q <= mavg_pkg::SAMPLE_W'(neg_q ? -quo_q : quo_q);
			fill_q <= mavg_pkg::FILL_W'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.div_done = (step_q == '0);
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign mean            = mean_q;
	assign fill_count      = fill_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WINDOW)) else $error("Fill count exceeds the window.");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |-> (cnt_q != '0)) else $error("Division started by zero.");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(mean_q)))
		else $error("Pending result word overwritten.");

endmodule

// ===== rtl/moving_average_warmup_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average with warm-up
// Sliding-window mean over signed samples, divided by the current fill count.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// samples   in         sample (16 bit signed)
// results   out        mean (16 bit signed), fill_count (4 bit)
//
// Each word is captured, read against the ring, added to the running sum and then
// divided by the one-bit-per-cycle restoring divider before it reaches the result.
// A new sample is taken only once the previous result sits in the output register,
// so a new word is not accepted before the last one is through the divider.
// Reset clears the pointer, fill count, sum and all handshake state; no clearing pass.
// A stalled result holds in the output register while the next sample is processed.
// ----------------------------------------------------------------------------
module moving_average_warmup_top #(
	parameter int WINDOW = 8
) (
	input logic      clk,
	input logic      arst_n,
	mavg_smp_if.sink   samples,
	mavg_res_if.source results
);

	mavg_pkg::mavg_cmd_t    cmd;
	mavg_pkg::mavg_status_t status;

	mavg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(samples.valid),
		.in_ready(samples.ready),
		.status  (status),
		.cmd     (cmd)
	);

	mavg_dpath #(
		.WINDOW(WINDOW)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.sample    (samples.sample),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.mean      (results.mean),
		.fill_count(results.fill_count)
	);

endmodule
